[hdl/jbhp_pkg.sv]
// Package: event codes, parser phases, command and status types
package jbhp_pkg;

  localparam logic [3:0] EV_QUANT   = 4'd0;
  localparam logic [3:0] EV_FRAME   = 4'd1;
  localparam logic [3:0] EV_COMP    = 4'd2;
  localparam logic [3:0] EV_HUFF    = 4'd3;
  localparam logic [3:0] EV_SCAN    = 4'd4;
  localparam logic [3:0] EV_DONE    = 4'd5;
  localparam logic [3:0] EV_UNKNOWN = 4'd6;
  localparam logic [3:0] EV_BAD_SOI = 4'd7;
  localparam logic [3:0] EV_BAD_DQT = 4'd8;
  localparam logic [3:0] EV_BAD_DHT = 4'd9;
  localparam logic [3:0] EV_BAD_SOS = 4'd10;

  localparam logic [15:0] MK_SOI  = 16'hFFD8;
  localparam logic [15:0] MK_APP0 = 16'hFFE0;
  localparam logic [15:0] MK_COM  = 16'hFFFE;
  localparam logic [15:0] MK_DQT  = 16'hFFDB;
  localparam logic [15:0] MK_DHT  = 16'hFFC4;
  localparam logic [15:0] MK_SOF0 = 16'hFFC0;
  localparam logic [15:0] MK_SOS  = 16'hFFDA;
  localparam logic [6:0]  QUANT_ENTRIES = 7'd64;

  typedef enum logic [17:0] {
    PH_SOI_HI    = 18'h00001,
    PH_SOI_LO    = 18'h00002,
    PH_MARK_HI   = 18'h00004,
    PH_MARK_LO   = 18'h00008,
    PH_LEN_HI    = 18'h00010,
    PH_LEN_LO    = 18'h00020,
    PH_SKIP      = 18'h00040,
    PH_DQT_HEAD  = 18'h00080,
    PH_DQT_ENTRY = 18'h00100,
    PH_SOF_HEAD  = 18'h00200,
    PH_SOF_COMP  = 18'h00400,
    PH_DHT_HEAD  = 18'h00800,
    PH_DHT_COUNT = 18'h01000,
    PH_DHT_CODES = 18'h02000,
    PH_SOS_COUNT = 18'h04000,
    PH_SOS_COMP  = 18'h08000,
    PH_DONE      = 18'h10000,
    PH_HALT      = 18'h20000
  } phase_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [1:0]  slot;
    logic [5:0]  position;
    logic [15:0] value;
    logic [15:0] second_value;
    logic [3:0]  factor_h;
    logic [3:0]  factor_v;
    logic [7:0]  table_a;
    logic [3:0]  table_b;
    logic        table_class;
    logic [2:0]  component_count;
  } event_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [15:0] word;
    logic        rem_zero_next;
    logic        len_le2;
    logic [7:0]  byte_counter;
    logic [2:0]  frame_components;
    logic [7:0]  frame_total;
    logic [7:0]  item_index;
    logic [7:0]  scan_total;
    logic [11:0] code_total;
    logic [11:0] code_sum;
  } dp_status_t;

  // controller commands to the datapath
  typedef struct packed {
    logic   step;
    phase_t phase;
    phase_t seg_kind;
  } dp_cmd_t;

endpackage

[hdl/jbhp_ctrl.sv]
// Controller: phase state machine and segment kind
module jbhp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  jbhp_pkg::dp_status_t st,
  output jbhp_pkg::dp_cmd_t   cmd
);
  import jbhp_pkg::*;

  phase_t phase, phase_next, body_next;
  phase_t seg_kind, seg_kind_next;
  logic   nolen;
  logic [7:0] lo;

  always_comb begin
    lo = st.word[7:0];
    nolen = (st.word[15:8] != 8'hFF) || lo == 8'h00 || lo == 8'h01 || lo == 8'hFF ||
            (lo >= 8'hD0 && lo <= 8'hD9);
  end

  always_comb begin
    body_next = phase;
    case (phase)
      PH_DQT_HEAD:  body_next = (data_byte[7:4] != 4'd0) ? PH_HALT : PH_DQT_ENTRY;
      PH_DQT_ENTRY: body_next = (st.byte_counter == 8'd63) ? PH_DQT_HEAD : PH_DQT_ENTRY;
      PH_SOF_HEAD:
        if (st.byte_counter >= 8'd5) begin
          body_next = (data_byte != 8'd0) ? PH_SOF_COMP : PH_SKIP;
        end
      PH_SOF_COMP:
        if (st.byte_counter >= 8'd2 && (st.item_index + 8'd1) >= st.frame_total) begin
          body_next = PH_SKIP;
        end
      PH_DHT_HEAD:  body_next = (data_byte[7:5] != 3'd0) ? PH_HALT : PH_DHT_COUNT;
      PH_DHT_COUNT:
        if (st.byte_counter == 8'd15) begin
          body_next = (st.code_sum != 12'd0) ? PH_DHT_CODES : PH_DHT_HEAD;
        end
      PH_DHT_CODES: if (st.code_total == 12'd1) body_next = PH_DHT_HEAD;
      PH_SOS_COUNT:
        if (data_byte != {5'd0, st.frame_components}) body_next = PH_HALT;
        else body_next = (data_byte != 8'd0) ? PH_SOS_COMP : PH_SKIP;
      PH_SOS_COMP:
        if (st.byte_counter != 8'd0 && (st.item_index + 8'd1) >= st.scan_total) begin
          body_next = PH_SKIP;
        end
      default: body_next = phase;
    endcase
  end

  always_comb begin
    phase_next = phase;
    seg_kind_next = seg_kind;
    case (phase)
      PH_SOI_HI:  phase_next = PH_SOI_LO;
      PH_MARK_HI: phase_next = PH_MARK_LO;
      PH_SOI_LO:  phase_next = (st.word == MK_SOI) ? PH_MARK_HI : PH_HALT;
      PH_MARK_LO: begin
        phase_next = PH_LEN_HI;
        case (st.word)
          MK_APP0, MK_COM: seg_kind_next = PH_SKIP;
          MK_DQT:  seg_kind_next = PH_DQT_HEAD;
          MK_SOF0: seg_kind_next = PH_SOF_HEAD;
          MK_DHT:  seg_kind_next = PH_DHT_HEAD;
          MK_SOS:  seg_kind_next = PH_SOS_COUNT;
          default: begin
            seg_kind_next = PH_SKIP;
            if (nolen) phase_next = PH_MARK_HI;
          end
        endcase
      end
      PH_LEN_HI: phase_next = PH_LEN_LO;
      PH_LEN_LO:
        if (st.len_le2) phase_next = (seg_kind == PH_SOS_COUNT) ? PH_DONE : PH_MARK_HI;
        else phase_next = seg_kind;
      PH_DONE, PH_HALT: phase_next = phase;
      default:
        if (body_next == PH_HALT) phase_next = PH_HALT;
        else if (st.rem_zero_next) phase_next = (seg_kind == PH_SOS_COUNT) ? PH_DONE : PH_MARK_HI;
        else phase_next = body_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SOI_HI;
      seg_kind <= PH_SKIP;
    end else if (step) begin
      phase <= phase_next;
      seg_kind <= seg_kind_next;
    end
  end

  assign cmd.step = step;
  assign cmd.phase = phase;
  assign cmd.seg_kind = seg_kind;
endmodule

[hdl/jbhp_dp.sv]
// Datapath: counters, field assembly, component store and event build
module jbhp_dp #(
  parameter int MAX_COMPONENTS = 4,
  parameter int TABLE_SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  jbhp_pkg::dp_cmd_t    cmd,
  output jbhp_pkg::dp_status_t st,
  output logic                 ev_valid,
  output jbhp_pkg::event_t     ev,
  output logic                 done_valid,
  output jbhp_pkg::event_t     done_ev
);
  import jbhp_pkg::*;

  logic [15:0] remaining_length;
  logic [7:0]  byte_counter;
  logic [15:0] field_shift;
  logic [1:0]  current_table;
  logic [11:0] code_total;
  logic [7:0]  stored_ids [MAX_COMPONENTS];
  logic [2:0]  frame_components;
  logic [7:0]  quant_table_count, huffman_table_count;
  logic [7:0]  item_index, scan_total, frame_precision, frame_total;
  logic [15:0] frame_height;
  logic [15:0] word, rem_next;
  logic [1:0]  slot_mod;
  logic        body, match_found, body_ends;
  logic [1:0]  match_pos;

  assign word = {field_shift[7:0], data_byte};
  assign rem_next = remaining_length - 16'd1;
  assign body = !(cmd.phase inside {PH_SOI_HI, PH_SOI_LO, PH_MARK_HI, PH_MARK_LO,
                   PH_LEN_HI, PH_LEN_LO, PH_DONE, PH_HALT});

  always_comb begin
    slot_mod = '0;
    for (int k = 0; k < 16; k++) begin
      if (data_byte[3:0] == 4'(k)) slot_mod = 2'(k % TABLE_SLOTS);
    end
  end

  always_comb begin
    match_found = 1'b0;
    match_pos = '0;
    for (int j = MAX_COMPONENTS - 1; j >= 0; j--) begin
      if (3'(j) < frame_components && stored_ids[j] == field_shift[7:0]) begin
        match_found = 1'b1;
        match_pos = 2'(j);
      end
    end
  end

  assign st.word = word;
  assign st.rem_zero_next = (rem_next == 16'd0);
  assign st.len_le2 = (word <= 16'd2);
  assign st.byte_counter = byte_counter;
  assign st.frame_components = frame_components;
  assign st.frame_total = frame_total;
  assign st.item_index = item_index;
  assign st.scan_total = scan_total;
  assign st.code_total = code_total;
  assign st.code_sum = code_total + {4'd0, data_byte};

  // does this body byte end the scan header without a halt
  always_comb begin
    body_ends = body && (rem_next == 16'd0) && cmd.seg_kind == PH_SOS_COUNT;
    if (cmd.phase == PH_DQT_HEAD && data_byte[7:4] != 4'd0) body_ends = 1'b0;
    if (cmd.phase == PH_DHT_HEAD && data_byte[7:5] != 3'd0) body_ends = 1'b0;
    if (cmd.phase == PH_SOS_COUNT && data_byte != {5'd0, frame_components}) body_ends = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_length <= '0; byte_counter <= '0; field_shift <= '0;
      current_table <= '0; code_total <= '0; frame_components <= '0;
      quant_table_count <= '0; huffman_table_count <= '0; item_index <= '0;
      scan_total <= '0; frame_precision <= '0; frame_total <= '0; frame_height <= '0;
    end else if (cmd.step) begin
      if (body) remaining_length <= rem_next;
      case (cmd.phase)
        PH_SOI_HI, PH_MARK_HI, PH_LEN_HI: field_shift <= {8'd0, data_byte};
        PH_LEN_LO: begin
          remaining_length <= (word >= 16'd2) ? word - 16'd2 : 16'd0;
          byte_counter <= '0;
        end
        PH_DQT_HEAD: begin
          current_table <= slot_mod;
          byte_counter <= '0;
        end
        PH_DQT_ENTRY: begin
          byte_counter <= byte_counter + 8'd1;
          if (byte_counter == 8'(QUANT_ENTRIES - 7'd1))
            quant_table_count <= quant_table_count + 8'd1;
        end
        PH_SOF_HEAD: begin
          byte_counter <= byte_counter + 8'd1;
          case (byte_counter)
            8'd0: frame_precision <= data_byte;
            8'd1: field_shift <= {8'd0, data_byte};
            8'd2: frame_height <= word;
            8'd3: field_shift <= {8'd0, data_byte};
            8'd4: field_shift <= word;
            default: begin
              frame_total <= data_byte;
              frame_components <= (data_byte > 8'(MAX_COMPONENTS)) ?
                                  3'(MAX_COMPONENTS) : data_byte[2:0];
              item_index <= '0;
              byte_counter <= '0;
            end
          endcase
        end
        PH_SOF_COMP: begin
          if (byte_counter == 8'd0) begin
            field_shift <= {8'd0, data_byte};
            byte_counter <= 8'd1;
          end else if (byte_counter == 8'd1) begin
            field_shift <= word;
            byte_counter <= 8'd2;
          end else begin
            if (item_index < 8'(MAX_COMPONENTS))
              stored_ids[item_index[1:0]] <= field_shift[15:8];
            item_index <= item_index + 8'd1;
            byte_counter <= '0;
          end
        end
        PH_DHT_HEAD:
          if (data_byte[7:5] == 3'd0) begin
            huffman_table_count <= huffman_table_count + 8'd1;
            code_total <= '0;
            byte_counter <= '0;
          end
        PH_DHT_COUNT: begin
          code_total <= code_total + {4'd0, data_byte};
          byte_counter <= byte_counter + 8'd1;
        end
        PH_DHT_CODES: code_total <= code_total - 12'd1;
        PH_SOS_COUNT: begin
          scan_total <= data_byte;
          item_index <= '0;
          byte_counter <= '0;
        end
        PH_SOS_COMP:
          if (byte_counter == 8'd0) begin
            field_shift <= {8'd0, data_byte};
            byte_counter <= 8'd1;
          end else begin
            item_index <= item_index + 8'd1;
            byte_counter <= '0;
          end
        default: ;
      endcase
    end
  end

  // build the first event that a byte gives
  always_comb begin
    ev = '0;
    ev_valid = 1'b0;
    case (cmd.phase)
      PH_SOI_LO:
        if (word != MK_SOI) begin
          ev_valid = 1'b1; ev.event_res = EV_BAD_SOI; ev.value = word;
        end
      PH_MARK_LO:
        if (!(word == MK_APP0 || word == MK_COM || word == MK_DQT || word == MK_SOF0 ||
              word == MK_DHT || word == MK_SOS)) begin
          ev_valid = 1'b1; ev.event_res = EV_UNKNOWN; ev.value = word;
        end
      PH_DQT_HEAD:
        if (data_byte[7:4] != 4'd0) begin
          ev_valid = 1'b1; ev.event_res = EV_BAD_DQT; ev.value = {8'd0, data_byte};
        end
      PH_DQT_ENTRY: begin
        ev_valid = 1'b1; ev.event_res = EV_QUANT; ev.slot = current_table;
        ev.position = byte_counter[5:0]; ev.value = {8'd0, data_byte};
      end
      PH_SOF_HEAD:
        if (byte_counter >= 8'd5) begin
          ev_valid = 1'b1; ev.event_res = EV_FRAME; ev.value = frame_height;
          ev.second_value = field_shift; ev.table_a = frame_precision;
          ev.component_count = (data_byte > 8'(MAX_COMPONENTS)) ?
                               3'(MAX_COMPONENTS) : data_byte[2:0];
        end
      PH_SOF_COMP:
        if (byte_counter >= 8'd2 && item_index < 8'(MAX_COMPONENTS)) begin
          ev_valid = 1'b1; ev.event_res = EV_COMP; ev.slot = item_index[1:0];
          ev.value = {8'd0, field_shift[15:8]}; ev.factor_h = field_shift[7:4];
          ev.factor_v = field_shift[3:0]; ev.table_a = data_byte;
        end
      PH_DHT_HEAD: begin
        ev_valid = 1'b1;
        if (data_byte[7:5] != 3'd0) begin
          ev.event_res = EV_BAD_DHT; ev.value = {8'd0, data_byte};
        end else begin
          ev.event_res = EV_HUFF; ev.slot = slot_mod; ev.table_class = data_byte[4];
        end
      end
      PH_SOS_COUNT:
        if (data_byte != {5'd0, frame_components}) begin
          ev_valid = 1'b1; ev.event_res = EV_BAD_SOS; ev.value = {8'd0, data_byte};
        end
      PH_SOS_COMP:
        if (byte_counter != 8'd0 && match_found) begin
          ev_valid = 1'b1; ev.event_res = EV_SCAN; ev.slot = match_pos;
          ev.value = {8'd0, field_shift[7:0]}; ev.table_a = {4'd0, data_byte[7:4]};
          ev.table_b = data_byte[3:0];
        end
      default: ;
    endcase
  end

  // done event at the end of the scan header, second after any first event of the same byte
  always_comb begin
    done_ev = '0;
    done_ev.event_res = EV_DONE;
    done_ev.value = {8'd0, quant_table_count};
    done_ev.second_value = {8'd0, huffman_table_count};
    done_ev.component_count = frame_components;
    done_valid = body_ends ||
                 (cmd.phase == PH_LEN_LO && word <= 16'd2 && cmd.seg_kind == PH_SOS_COUNT);
  end
endmodule

[hdl/jpeg_baseline_header_parser.sv]
// Top level: baseline JPEG header parser with event output register
// The first event of an accepted byte is registered and shows on m_axis in the cycle after the byte is accepted.
// Throughput: one byte per cycle; a scan component byte that also ends the header
// gives two events and holds the input until the second event is loaded.
// The output register parts the sides; input stalls while it is full and not taken.
// Reset (rst, synchronous) returns to waiting for the start-of-image marker.
module jpeg_baseline_header_parser #(
  parameter int MAX_COMPONENTS = 4,
  parameter int TABLE_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // event_res, slot, position, value, second_value,
                                      // factor_h, factor_v, table_a, table_b,
                                      // table_class, component_count, 4 zero bits
);
  import jbhp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  event_t     ev, done_ev;
  logic       ev_valid, done_valid, step;

  jbhp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .step(step), .data_byte(s_axis_tdata),
    .st(st), .cmd(cmd)
  );

  jbhp_dp #(.MAX_COMPONENTS(MAX_COMPONENTS), .TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .data_byte(s_axis_tdata), .cmd(cmd), .st(st),
    .ev_valid(ev_valid), .ev(ev), .done_valid(done_valid), .done_ev(done_ev)
  );

  logic   ovalid, pend;
  event_t oev, pend_ev;
  logic   room;

  assign room = !ovalid || m_axis_tready;
  assign s_axis_tready = room && !pend;
  assign step = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      pend <= 1'b0;
    end else if (room) begin
      if (pend) begin
        ovalid <= 1'b1; oev <= pend_ev; pend <= 1'b0;
      end else if (step && ev_valid && done_valid) begin
        ovalid <= 1'b1; oev <= ev; pend <= 1'b1; pend_ev <= done_ev;
      end else if (step && ev_valid) begin
        ovalid <= 1'b1; oev <= ev;
      end else if (step && done_valid) begin
        ovalid <= 1'b1; oev <= done_ev;
      end else begin
        ovalid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata = {4'd0, oev.component_count, oev.table_class, oev.table_b,
                         oev.table_a, oev.factor_v, oev.factor_h, oev.second_value,
                         oev.value, oev.position, oev.slot, oev.event_res};
endmodule

[hdl/jbhp_checker.sv]
// Checker: port-level properties of the header parser
module jbhp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped");
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd10)
    else $error("bad event code");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output after reset");
endmodule

bind jpeg_baseline_header_parser jbhp_checker u_chk (.*);

[bench/jpeg_baseline_header_parser_tb.sv]
// Testbench: byte-stream stimulus for the JPEG header parser with a scoreboard of header events
module jpeg_baseline_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jbhp_pkg::*;

  localparam int SLOTS = 4;
  localparam int COMPS = 4;
  localparam int QUIET_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  jpeg_baseline_header_parser dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  event_t      pending_events[$];
  logic [7:0]  seg_body[$];
  int          src_idle = 33;
  int          sink_idle = 60;
  int          hold_cycles = 0;
  int          bytes_sent = 0;
  int          errors = 0;
  int          quiet = 0;

  // parser mirror
  phase_t      ph;
  phase_t      kind;
  logic [15:0] rem_len;
  logic [7:0]  cnt;
  logic [15:0] shift;
  logic [1:0]  cur_tab;
  logic [11:0] codes;
  logic [7:0]  ids[COMPS];
  logic [2:0]  fcomp;
  logic [7:0]  qcount;
  logic [7:0]  hcount;
  logic [7:0]  idx;
  logic [7:0]  scan_n;
  logic [15:0] height;
  logic [7:0]  prec;
  logic [7:0]  ftotal;

  function automatic event_t blank(logic [3:0] code);
    event_t e;
    e = '0;
    e.event_res = code;
    return e;
  endfunction

  task automatic halt_with(logic [3:0] code, logic [15:0] v);
    event_t e;
    e = blank(code);
    e.value = v;
    pending_events.push_back(e);
    ph = PH_HALT;
  endtask

  function automatic bit lengthless(logic [15:0] m);
    if (m[15:8] != 8'hFF) return 1'b1;
    return m[7:0] == 8'h00 || m[7:0] == 8'h01 || m[7:0] == 8'hFF ||
           (m[7:0] >= 8'hD0 && m[7:0] <= 8'hD9);
  endfunction

  task automatic close_segment();
    event_t e;
    if (kind == PH_SOS_COUNT) begin
      e = blank(EV_DONE);
      e.value = {8'h00, qcount};
      e.second_value = {8'h00, hcount};
      e.component_count = fcomp;
      pending_events.push_back(e);
      ph = PH_DONE;
    end else begin
      ph = PH_MARK_HI;
    end
  endtask

  task automatic body_byte(logic [7:0] b);
    event_t e;
    bit hit;
    case (ph)
      PH_DQT_HEAD: begin
        if (b[7:4] != 4'd0) halt_with(EV_BAD_DQT, {8'h00, b});
        else begin
          cur_tab = 2'(b[3:0] % SLOTS);
          cnt = 0;
          ph = PH_DQT_ENTRY;
        end
      end
      PH_DQT_ENTRY: begin
        e = blank(EV_QUANT);
        e.slot = cur_tab;
        e.position = cnt[5:0];
        e.value = {8'h00, b};
        pending_events.push_back(e);
        cnt++;
        if (cnt >= 64) begin
          qcount++;
          ph = PH_DQT_HEAD;
        end
      end
      PH_SOF_HEAD: begin
        case (cnt)
          0: prec = b;
          1: shift = {8'h00, b};
          2: height = {shift[7:0], b};
          3: shift = {8'h00, b};
          4: shift = {shift[7:0], b};
          default: begin
            ftotal = b;
            fcomp = (b > COMPS) ? 3'(COMPS) : b[2:0];
            e = blank(EV_FRAME);
            e.value = height;
            e.second_value = shift;
            e.table_a = prec;
            e.component_count = fcomp;
            pending_events.push_back(e);
            idx = 0;
            ph = (b != 0) ? PH_SOF_COMP : PH_SKIP;
          end
        endcase
        cnt++;
        if (ph != PH_SOF_HEAD) cnt = 0;
      end
      PH_SOF_COMP: begin
        if (cnt == 0) begin
          shift = {8'h00, b};
          cnt = 1;
        end else if (cnt == 1) begin
          shift = {shift[7:0], b};
          cnt = 2;
        end else begin
          if (idx < COMPS) begin
            ids[idx[1:0]] = shift[15:8];
            e = blank(EV_COMP);
            e.slot = idx[1:0];
            e.value = {8'h00, shift[15:8]};
            e.factor_h = shift[7:4];
            e.factor_v = shift[3:0];
            e.table_a = b;
            pending_events.push_back(e);
          end
          idx++;
          cnt = 0;
          if (idx >= ftotal) ph = PH_SKIP;
        end
      end
      PH_DHT_HEAD: begin
        if ((b & 8'hE0) != 0) halt_with(EV_BAD_DHT, {8'h00, b});
        else begin
          e = blank(EV_HUFF);
          e.slot = 2'(b[3:0] % SLOTS);
          e.table_class = b[4];
          pending_events.push_back(e);
          hcount++;
          codes = 0;
          cnt = 0;
          ph = PH_DHT_COUNT;
        end
      end
      PH_DHT_COUNT: begin
        codes = codes + 12'(b);
        cnt++;
        if (cnt >= 16) ph = (codes != 0) ? PH_DHT_CODES : PH_DHT_HEAD;
      end
      PH_DHT_CODES: begin
        codes--;
        if (codes == 0) ph = PH_DHT_HEAD;
      end
      PH_SOS_COUNT: begin
        if (b != {5'd0, fcomp}) halt_with(EV_BAD_SOS, {8'h00, b});
        else begin
          scan_n = b;
          idx = 0;
          cnt = 0;
          ph = (b != 0) ? PH_SOS_COMP : PH_SKIP;
        end
      end
      PH_SOS_COMP: begin
        if (cnt == 0) begin
          shift = {8'h00, b};
          cnt = 1;
        end else begin
          hit = 1'b0;
          for (int j = 0; j < COMPS; j++) begin
            if (!hit && j < fcomp && {8'h00, ids[j]} == shift) begin
              hit = 1'b1;
              e = blank(EV_SCAN);
              e.slot = 2'(j);
              e.value = shift;
              e.table_a = {4'h0, b[7:4]};
              e.table_b = b[3:0];
              pending_events.push_back(e);
            end
          end
          idx++;
          cnt = 0;
          if (idx >= scan_n) ph = PH_SKIP;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(logic [7:0] b);
    logic [15:0] w;
    event_t e;
    w = {shift[7:0], b};
    case (ph)
      PH_SOI_HI, PH_MARK_HI: begin
        shift = {8'h00, b};
        ph = (ph == PH_SOI_HI) ? PH_SOI_LO : PH_MARK_LO;
      end
      PH_SOI_LO: begin
        if (w != MK_SOI) halt_with(EV_BAD_SOI, w);
        else ph = PH_MARK_HI;
      end
      PH_MARK_LO: begin
        ph = PH_LEN_HI;
        case (w)
          MK_APP0, MK_COM: kind = PH_SKIP;
          MK_DQT:  kind = PH_DQT_HEAD;
          MK_SOF0: kind = PH_SOF_HEAD;
          MK_DHT:  kind = PH_DHT_HEAD;
          MK_SOS:  kind = PH_SOS_COUNT;
          default: begin
            e = blank(EV_UNKNOWN);
            e.value = w;
            pending_events.push_back(e);
            kind = PH_SKIP;
            if (lengthless(w)) ph = PH_MARK_HI;
          end
        endcase
      end
      PH_LEN_HI: begin
        shift = {8'h00, b};
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        rem_len = (w >= 2) ? w - 16'd2 : 16'd0;
        cnt = 0;
        ph = kind;
        if (rem_len == 0) close_segment();
      end
      PH_DONE, PH_HALT: ;
      default: begin
        rem_len--;
        body_byte(b);
        if (ph != PH_HALT && rem_len == 0) close_segment();
      end
    endcase
  endtask

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk iff s_axis_tready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_marker(logic [15:0] mk);
    send_byte(mk[15:8]);
    send_byte(mk[7:0]);
  endtask

  // body bytes beyond the length field are never sent
  task automatic send_segment(logic [15:0] mk, logic [15:0] len);
    int n;
    n = (len >= 2) ? len - 2 : 0;
    send_marker(mk);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < n && i < seg_body.size(); i++) send_byte(seg_body[i]);
  endtask

  task automatic put_random(int n);
    for (int i = 0; i < n; i++) seg_body.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_dqt(int tables, bit extremes);
    for (int t = 0; t < tables; t++) begin
      seg_body.push_back({4'h0, 4'($urandom_range(0, 15))});
      for (int i = 0; i < 64; i++)
        seg_body.push_back(extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_sof(int ncomp);
    seg_body.push_back(8'($urandom_range(0, 255)));
    put_random(4);
    seg_body.push_back(8'(ncomp));
    put_random(3 * ncomp);
  endtask

  task automatic build_dht(int tables);
    int sum;
    for (int t = 0; t < tables; t++) begin
      seg_body.push_back(8'($urandom_range(0, 31)));
      sum = 0;
      for (int i = 0; i < 16; i++) begin
        seg_body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'h00);
        sum += seg_body[seg_body.size() - 1];
      end
      put_random(sum);
    end
  endtask

  function automatic logic [15:0] cut_length(int full);
    if ($urandom_range(0, 3) != 0) return 16'(full);
    return 16'($urandom_range(0, full));
  endfunction

  task automatic random_segment();
    logic [15:0] mk;
    seg_body.delete();
    case ($urandom_range(0, 9))
      0, 1, 9: begin
        build_dqt($urandom_range(1, 2), 1'b0);
        send_segment(MK_DQT, cut_length(seg_body.size() + 2));
      end
      2: begin
        if ($urandom_range(0, 7) == 0) send_segment(MK_SOF0, 16'($urandom_range(0, 2)));
        else begin
          build_sof($urandom_range(0, 6));
          put_random($urandom_range(0, 3));
          send_segment(MK_SOF0, 16'(seg_body.size() + 2));
        end
      end
      3, 4: begin
        build_dht($urandom_range(1, 3));
        send_segment(MK_DHT, cut_length(seg_body.size() + 2));
      end
      5: begin
        put_random($urandom_range(0, 8));
        send_segment(MK_APP0, cut_length(seg_body.size() + 2));
      end
      6: begin
        put_random($urandom_range(0, 8));
        send_segment(MK_COM, cut_length(seg_body.size() + 2));
      end
      7: begin
        put_random($urandom_range(0, 6));
        send_segment({8'hFF, 8'($urandom_range(8'hE1, 8'hEF))}, 16'(seg_body.size() + 2));
      end
      default: begin
        case ($urandom_range(0, 4))
          0: mk = {8'($urandom_range(0, 254)), 8'($urandom_range(0, 255))};
          1: mk = 16'hFF00;
          2: mk = 16'hFF01;
          3: mk = 16'hFFFF;
          default: mk = {8'hFF, 8'($urandom_range(8'hD0, 8'hD9))};
        endcase
        send_marker(mk);
      end
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_marker(MK_SOI);
    seg_body.delete();
    send_segment(MK_APP0, 16'd2);
    send_segment(MK_COM, 16'd0);
    send_marker(16'hFF01);
    send_marker(16'h00FF);
    seg_body.delete();
    seg_body.push_back(8'hA5);
    send_segment(16'hFFE5, 16'd3);
    seg_body.delete();
    seg_body.push_back(8'h0F);
    seg_body.push_back(8'hFF);
    seg_body.push_back(8'h00);
    send_segment(MK_DQT, 16'd5);
    seg_body.delete();
    send_segment(MK_DHT, 16'd1);
  endtask

  task automatic test_random(int target);
    while (bytes_sent < target) random_segment();
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 300;
    seg_body.delete();
    build_dqt(1, 1'b1);
    send_segment(MK_DQT, 16'(seg_body.size() + 2));
    seg_body.delete();
    build_sof(5);
    send_segment(MK_SOF0, 16'(seg_body.size() + 2));
    wait_drained();
  endtask

  task automatic test_header_end();
    int n;
    seg_body.delete();
    case ($urandom_range(0, 5))
      0, 1: begin
        n = fcomp;
        seg_body.push_back(8'(n));
        for (int i = 0; i < n; i++) begin
          seg_body.push_back(($urandom_range(0, 3) != 0) ? ids[$urandom_range(0, n - 1)]
                                                         : 8'($urandom_range(0, 255)));
          seg_body.push_back(8'($urandom_range(0, 255)));
        end
        put_random($urandom_range(0, 2));
        send_segment(MK_SOS, 16'(seg_body.size() + 2));
      end
      2: send_segment(MK_SOS, 16'd2);
      3: begin
        seg_body.push_back(8'(fcomp + 1));
        send_segment(MK_SOS, 16'd6);
      end
      4: begin
        seg_body.push_back(8'($urandom_range(16, 255)));
        send_segment(MK_DQT, 16'd70);
      end
      default: begin
        seg_body.push_back(8'($urandom_range(32, 255)));
        send_segment(MK_DHT, 16'd20);
      end
    endcase
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)));
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    event_t want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", want.event_res, m_axis_tdata[3:0]);
          check_field("slot", want.slot, m_axis_tdata[5:4]);
          check_field("position", want.position, m_axis_tdata[11:6]);
          check_field("value", want.value, m_axis_tdata[27:12]);
          check_field("second_value", want.second_value, m_axis_tdata[43:28]);
          check_field("factor_h", want.factor_h, m_axis_tdata[47:44]);
          check_field("factor_v", want.factor_v, m_axis_tdata[51:48]);
          check_field("table_a", want.table_a, m_axis_tdata[59:52]);
          check_field("table_b", want.table_b, m_axis_tdata[63:60]);
          check_field("table_class", want.table_class, m_axis_tdata[64]);
          check_field("component_count", want.component_count, m_axis_tdata[67:65]);
        end
      end
    end
  end

  initial begin
    ph = PH_SOI_HI;
    kind = PH_SOI_HI;
    rem_len = '0;
    cnt = '0;
    shift = '0;
    cur_tab = '0;
    codes = '0;
    fcomp = '0;
    qcount = '0;
    hcount = '0;
    idx = '0;
    scan_n = '0;
    height = '0;
    prec = '0;
    ftotal = '0;
    for (int i = 0; i < COMPS; i++) ids[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 33;
    sink_idle = 60;
    test_directed();
    test_random(90);
    test_backpressure();
    src_idle = 60;
    sink_idle = 33;
    test_random(170);
    src_idle = 0;
    sink_idle = 0;
    test_random(250);
    test_header_end();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[files.f]
hdl/jbhp_pkg.sv
hdl/jbhp_ctrl.sv
hdl/jbhp_dp.sv
hdl/jpeg_baseline_header_parser.sv
hdl/jbhp_checker.sv
bench/jpeg_baseline_header_parser_tb.sv
